@@ hdl/bcomp_pkg.sv @@
// Shared types, register indexes and constants for the barometric compensation block.
// No dependencies; every other file imports this package.
package bcomp_pkg;

  localparam int CFG_W     = 64;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_CALIB_T  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CALIB_PA = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CALIB_PB = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CALIB_PC = 2'd3;

  localparam logic [31:0] T_ROUND     = 32'd128;
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] P_BASE      = 64'd1048576;
  localparam logic [63:0] P_SCALE     = 64'd3125;
  localparam logic [63:0] VAR_BIAS    = 64'd1 << 47;
  localparam logic [63:0] Q8_ROUND    = 64'd255;

  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic [19:0] adc_pressure;
    logic [19:0] adc_temperature;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } op_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } op_rsp_t;

  function automatic logic [63:0] sra64(input logic [63:0] x, input logic [5:0] n);
    sra64 = 64'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
    sra32 = 32'($signed(x) >>> n);
  endfunction

endpackage

@@ hdl/bcomp_front.sv @@
// Input side: a two-entry queue that takes samples and hands them to the sequencer.
// Depends on bcomp_pkg.
module bcomp_front import bcomp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  sample,
  output logic item_valid,
  output in_t  item,
  input  logic item_take
);

  in_t        slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_take;

  assign full       = count[1];
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule

@@ hdl/bcomp_mul.sv @@
// Shared 64x64 multiplier giving the low 64 product bits from three 32x32 partial products.
// Depends on bcomp_pkg.
module bcomp_mul import bcomp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  op_req_t req,
  output op_rsp_t rsp
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LL   = 3'd1;
  localparam logic [2:0] PH_LH   = 3'd2;
  localparam logic [2:0] PH_HL   = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [2:0]  phase;
  logic        done;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] part;

  assign x    = (phase == PH_HL) ? a_r[63:32] : a_r[31:0];
  assign y    = (phase == PH_LH) ? b_r[63:32] : b_r[31:0];
  assign part = 64'(x) * 64'(y);

  assign rsp.done = done;
  assign rsp.res  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_r   <= req.a;
        b_r   <= req.b;
        phase <= PH_LL;
      end else begin
        case (phase)
          PH_LL: begin
            prod  <= part;
            phase <= PH_LH;
          end
          PH_LH: begin
            acc   <= prod;
            prod  <= part;
            phase <= PH_HL;
          end
          PH_HL: begin
            acc   <= acc + {prod[31:0], 32'd0};
            prod  <= part;
            phase <= PH_SUM;
          end
          PH_SUM: begin
            acc   <= acc + {prod[31:0], 32'd0};
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
          default: phase <= PH_IDLE;
        endcase
      end
    end
  end

endmodule

@@ hdl/bcomp_div.sv @@
// Signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on bcomp_pkg.
module bcomp_div import bcomp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  op_req_t req,
  output op_rsp_t rsp
);

  logic [63:0]          rem;
  logic [63:0]          quo;
  logic [63:0]          mb;
  logic [63:0]          q;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 fix;
  logic                 done;
  logic [64:0]          trial;
  logic                 borrow;

  assign trial  = {rem, quo[63]} - {1'b0, mb};
  assign borrow = trial[64];

  assign rsp.done = done;
  assign rsp.res  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= req.a[63] ^ req.b[63];
        quo <= req.a[63] ? (64'd0 - req.a) : req.a;
        mb  <= req.b[63] ? (64'd0 - req.b) : req.b;
        rem <= '0;
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt != '0) begin
        rem <= borrow ? {rem[62:0], quo[63]} : trial[63:0];
        quo <= {quo[62:0], ~borrow};
        cnt <= cnt - 1'b1;
        fix <= (cnt == DIV_CNT_W'(1));
      end else if (fix) begin
        // apply the sign; the most negative quotient wraps to itself
        q    <= neg ? (64'd0 - quo) : quo;
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/bcomp_back.sv @@
// Sequencer that runs the compensation formulas on the shared multiplier and divider,
// holds the calibration registers and the two-entry result queue. Depends on bcomp_pkg.
module bcomp_back import bcomp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  input  logic                 item_valid,
  input  in_t                  item,
  output logic                 item_take,
  output logic                 empty,
  input  logic                 pop,
  output out_t                 result
);

  localparam logic [4:0] S_TA    = 5'd0;
  localparam logic [4:0] S_DD    = 5'd1;
  localparam logic [4:0] S_T3    = 5'd2;
  localparam logic [4:0] S_TEMP  = 5'd3;
  localparam logic [4:0] S_W1SQ  = 5'd4;
  localparam logic [4:0] S_P6    = 5'd5;
  localparam logic [4:0] S_P5    = 5'd6;
  localparam logic [4:0] S_P3    = 5'd7;
  localparam logic [4:0] S_P2    = 5'd8;
  localparam logic [4:0] S_P1    = 5'd9;
  localparam logic [4:0] S_NUM   = 5'd10;
  localparam logic [4:0] S_SCALE = 5'd11;
  localparam logic [4:0] S_DIV   = 5'd12;
  localparam logic [4:0] S_P9    = 5'd13;
  localparam logic [4:0] S_Q13   = 5'd14;
  localparam logic [4:0] S_P8    = 5'd15;
  localparam logic [4:0] S_SUM   = 5'd16;
  localparam logic [4:0] S_SUM2  = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  logic [47:0] calib_t;
  logic [63:0] calib_pa;
  logic [63:0] calib_pb;
  logic [15:0] calib_pc;

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic        busy;
  logic        issued;
  logic [4:0]  step;
  logic [19:0] adc_p;
  logic [31:0] ta, d, v1, xr, fine, temp;
  logic [63:0] w1, w1sq, w2, acc, dv, num, pv, tq, x1, x2;
  logic        zflag;

  op_req_t     mul_req, div_req;
  op_rsp_t     mul_rsp, div_rsp;
  logic        is_mul;
  logic [63:0] prod;
  logic [63:0] q13;
  logic [31:0] f5;
  logic [63:0] pround;
  logic [63:0] pdiff;

  out_t        oslot [2];
  logic [1:0]  ocount;
  logic        owr, ord;
  logic        out_full, out_push, out_pop;
  out_t        out_item;

  assign t1 = {16'd0, calib_t[15:0]};
  assign t2 = {{16{calib_t[31]}}, calib_t[31:16]};
  assign t3 = {{16{calib_t[47]}}, calib_t[47:32]};
  assign p1 = {48'd0, calib_pa[15:0]};
  assign p2 = {{48{calib_pa[31]}}, calib_pa[31:16]};
  assign p3 = {{48{calib_pa[47]}}, calib_pa[47:32]};
  assign p4 = {{48{calib_pa[63]}}, calib_pa[63:48]};
  assign p5 = {{48{calib_pb[15]}}, calib_pb[15:0]};
  assign p6 = {{48{calib_pb[31]}}, calib_pb[31:16]};
  assign p7 = {{48{calib_pb[47]}}, calib_pb[47:32]};
  assign p8 = {{48{calib_pb[63]}}, calib_pb[63:48]};
  assign p9 = {{48{calib_pc[15]}}, calib_pc};

  assign prod   = mul_rsp.res;
  assign q13    = sra64(pv, 6'd13);
  assign f5     = {fine[29:0], 2'b00} + fine + T_ROUND;
  assign pround = pv + (pv[63] ? Q8_ROUND : 64'd0);
  assign pdiff  = P_BASE - {44'd0, adc_p};

  assign item_take = !busy && item_valid;

  always_comb begin
    is_mul = step inside {S_TA, S_DD, S_T3, S_W1SQ, S_P6, S_P5, S_P3, S_P2, S_P1,
                          S_SCALE, S_P9, S_Q13, S_P8};
    mul_req.start = busy && is_mul && !issued;
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (step)
      S_TA: begin
        mul_req.a = {32'd0, ta};
        mul_req.b = {32'd0, t2};
      end
      S_DD: begin
        mul_req.a = {32'd0, d};
        mul_req.b = {32'd0, d};
      end
      S_T3: begin
        mul_req.a = {32'd0, xr};
        mul_req.b = {32'd0, t3};
      end
      S_W1SQ: begin
        mul_req.a = w1;
        mul_req.b = w1;
      end
      S_P6: begin
        mul_req.a = w1sq;
        mul_req.b = p6;
      end
      S_P5: begin
        mul_req.a = w1;
        mul_req.b = p5;
      end
      S_P3: begin
        mul_req.a = w1sq;
        mul_req.b = p3;
      end
      S_P2: begin
        mul_req.a = w1;
        mul_req.b = p2;
      end
      S_P1: begin
        mul_req.a = acc;
        mul_req.b = p1;
      end
      S_SCALE: begin
        mul_req.a = num;
        mul_req.b = P_SCALE;
      end
      S_P9: begin
        mul_req.a = q13;
        mul_req.b = p9;
      end
      S_Q13: begin
        mul_req.a = tq;
        mul_req.b = q13;
      end
      S_P8: begin
        mul_req.a = pv;
        mul_req.b = p8;
      end
      default: ;
    endcase
    div_req.start = busy && (step == S_DIV) && !issued;
    div_req.a     = num;
    div_req.b     = dv;
  end

  bcomp_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  bcomp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // result queue
  assign out_full = ocount[1];
  assign empty    = (ocount == 2'd0);
  assign result   = oslot[ord];
  assign out_pop  = pop && !empty;
  assign out_push = busy && (step == S_FIN) && !out_full;
  assign out_item = '{temperature_centi: temp,
                      pressure: zflag ? 32'd0 : pround[39:8]};

  always_ff @(posedge clk) begin
    if (out_push) begin
      oslot[owr] <= out_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= 2'd0;
      owr    <= 1'b0;
      ord    <= 1'b0;
    end else begin
      if (out_push) begin
        owr <= ~owr;
      end
      if (out_pop) begin
        ord <= ~ord;
      end
      ocount <= ocount + {1'b0, out_push} - {1'b0, out_pop};
    end
  end

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_t  <= '0;
      calib_pa <= '0;
      calib_pb <= '0;
      calib_pc <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CALIB_T:  calib_t  <= wr_data[47:0];
        REG_CALIB_PA: calib_pa <= wr_data;
        REG_CALIB_PB: calib_pb <= wr_data;
        REG_CALIB_PC: calib_pc <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      issued <= 1'b0;
      step   <= S_TA;
    end else if (!busy) begin
      if (item_valid) begin
        adc_p  <= item.adc_pressure;
        ta     <= ({12'd0, item.adc_temperature} >> 3) - {t1[30:0], 1'b0};
        d      <= ({12'd0, item.adc_temperature} >> 4) - t1;
        step   <= S_TA;
        issued <= 1'b0;
        busy   <= 1'b1;
      end
    end else if (is_mul) begin
      if (!issued) begin
        issued <= 1'b1;
      end else if (mul_rsp.done) begin
        issued <= 1'b0;
        step   <= step + 5'd1;
        case (step)
          S_TA:    v1   <= sra32(prod[31:0], 5'd11);
          S_DD:    xr   <= sra32(prod[31:0], 5'd12);
          S_T3:    fine <= v1 + sra32(prod[31:0], 5'd14);
          S_W1SQ:  w1sq <= prod;
          S_P6:    w2   <= prod + {p4[28:0], 35'd0};
          S_P5:    w2   <= w2 + {prod[46:0], 17'd0};
          S_P3:    acc  <= sra64(prod, 6'd8);
          S_P2:    acc  <= acc + {prod[51:0], 12'd0} + VAR_BIAS;
          S_P1:    dv   <= sra64(prod, 6'd33);
          S_SCALE: num  <= prod;
          S_P9:    tq   <= prod;
          S_Q13:   x1   <= sra64(prod, 6'd25);
          S_P8:    x2   <= sra64(prod, 6'd19);
          default: ;
        endcase
      end
    end else begin
      case (step)
        S_TEMP: begin
          temp <= sra32(f5, 5'd8);
          w1   <= {{32{fine[31]}}, fine} - FINE_OFFSET;
          step <= S_W1SQ;
        end
        S_NUM: begin
          zflag <= (dv == 64'd0);
          num   <= {pdiff[32:0], 31'd0} - w2;
          // skip the pressure work when the divisor is zero
          step  <= (dv == 64'd0) ? S_FIN : S_SCALE;
        end
        S_DIV: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (div_rsp.done) begin
            issued <= 1'b0;
            pv     <= div_rsp.res;
            step   <= S_P9;
          end
        end
        S_SUM: begin
          acc  <= sra64(pv + x1 + x2, 6'd8);
          step <= S_SUM2;
        end
        S_SUM2: begin
          pv   <= acc + {p7[59:0], 4'd0};
          step <= S_FIN;
        end
        S_FIN: begin
          if (!out_full) begin
            busy <= 1'b0;
            step <= S_TA;
          end
        end
        default: begin
          busy <= 1'b0;
          step <= S_TA;
        end
      endcase
    end
  end

endmodule

@@ hdl/barometric_compensation.sv @@
// Top level of the barometric compensation block: input queue plus compensation sequencer.
// Depends on bcomp_pkg, bcomp_front and bcomp_back.
//
// Each sample pair gives one result: temperature in hundredths of a degree and pressure in
// whole pascals. An item occupies the sequencer for thirteen 64-bit multiplies on one shared
// 32x32 multiplier, the divide (64 quotient bits plus the sign step and handshake) and the
// register steps between them; the scaling, divide and later pressure steps are skipped
// when the divisor is zero. Up to two samples wait at the input and
// two results at the output, so the next sample is taken while a result waits to be popped.
// Calibration writes land at once and must only be made while no sample is in flight.
module barometric_compensation import bcomp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_t                  sample,
  output logic                 empty,
  input  logic                 pop,
  output out_t                 result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  logic item_valid;
  in_t  item;
  logic item_take;

  bcomp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  bcomp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

@@ hdl/bcomp_checker.sv @@
// Port-level checks for barometric_compensation and the bind that attaches them.
// Depends on bcomp_pkg and the top level.
module bcomp_checker import bcomp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t result
);

  // transactions accepted and not yet popped
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + {2'd0, push && !full} - {2'd0, pop && !empty};
    end
  end

  a_reset_state: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (pending == 3'd0) |-> empty)
    else $error("result shown with no transaction outstanding");

  a_idle_accepts: assert property (@(posedge clk) disable iff (rst)
    (pending == 3'd0) |-> !full)
    else $error("input full while nothing is outstanding");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

endmodule

bind barometric_compensation bcomp_checker u_bcomp_checker (.*);
